// ===== rtl/pic_pkg.sv =====
// Shared types and constants for the piecewise linear interpolator.
// Holds opcode and status codes, datapath widths and the sequencer state type.
// No dependencies.
package pic_pkg;

    // Data widths of the Q16.16 datapath.
    localparam int DW = 32;            // breakpoint and result width
    localparam int MW = DW + 1;        // width of a difference and of its magnitude
    localparam int PW = 2 * DW + 1;    // product of two magnitudes
    localparam int QW = 34;            // quotient bits kept before overflow
    localparam int HW = PW - QW;       // product bits above the quotient window
    localparam int BW = 37;            // base value y2 +/- quotient, with margin
    localparam int CNTW = 6;           // divider step counter

    // Opcodes of an input beat.
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // Status codes of a result beat.
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_FULL  = 3'd1;
    localparam logic [2:0] ST_FEW   = 3'd2;
    localparam logic [2:0] ST_ZERO  = 3'd3;
    localparam logic [2:0] ST_SAT   = 3'd4;

    // Saturation limits.
    localparam logic signed [DW-1:0] Y_MAX = 32'sh7fff_ffff;
    localparam logic signed [DW-1:0] Y_MIN = 32'sh8000_0000;

    // Query sequencer states, one-hot.
    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_A0   = 13'b0000000000010,
        S_AL   = 13'b0000000000100,
        S_CMP  = 13'b0000000001000,
        S_SEGA = 13'b0000000010000,
        S_SEGB = 13'b0000000100000,
        S_GETB = 13'b0000001000000,
        S_DIFF = 13'b0000010000000,
        S_MUL  = 13'b0000100000000,
        S_OVF  = 13'b0001000000000,
        S_DIV  = 13'b0010000000000,
        S_BASE = 13'b0100000000000,
        S_DONE = 13'b1000000000000
    } t_state;

endpackage

// ===== rtl/pic_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Width and depth are parameters; no other dependencies.
module pic_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/piecewise_linear_interpolator_core.sv =====
// Piecewise linear interpolator core: breakpoint table in one RAM and a query sequencer.
// Depends on pic_pkg for codes and widths, and on pic_ram for the breakpoint table.
//
// A beat is taken when start is high and busy is low; every beat gives exactly one
// result beat, shown for one cycle with o_valid high, which the receiver must take.
// Clear, append, unused opcodes and queries on fewer than two points answer in the
// cycle after the beat and never raise busy. A query holds busy while it reads the
// first and last breakpoints, steps the forward search over segments when the target
// lies inside the table (one RAM read per step), forms the differences and their
// product, and runs the bit-serial restoring divider that forms the slope term.
// A zero-width segment ends the query at the differences, an overflowing quotient at
// the product check. Appends write the RAM at the beat; reads only happen in later
// query cycles, so one beat at a time keeps reads and writes apart.
module piecewise_linear_interpolator_core #(
    parameter int MAX_POINTS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_opcode,
    input  logic signed [31:0] i_x_value,
    input  logic signed [31:0] i_y_value,
    input  logic               i_first_query,
    output logic               o_valid,
    output logic signed [31:0] o_y_result,
    output logic [2:0]         o_status
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int DW = pic_pkg::DW;
    localparam int MW = pic_pkg::MW;
    localparam int PW = pic_pkg::PW;
    localparam int QW = pic_pkg::QW;
    localparam int HW = pic_pkg::HW;
    localparam int BW = pic_pkg::BW;
    localparam int CNTW = pic_pkg::CNTW;

    // Control state.
    pic_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_sp, n_sp;
    logic [AW-1:0]   r_last, n_last;
    logic [AW-1:0]   r_last_seg, n_last_seg;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic            r_valid, n_valid;

    // Payload registers.
    logic signed [DW-1:0] r_x, n_x;
    logic signed [DW-1:0] r_ax, n_ax;
    logic signed [DW-1:0] r_ay, n_ay;
    logic signed [DW-1:0] r_bx, n_bx;
    logic signed [DW-1:0] r_by, n_by;
    logic [MW-1:0]        r_ma, n_ma;
    logic [MW-1:0]        r_mb, n_mb;
    logic [MW-1:0]        r_dm, n_dm;
    logic                 r_neg, n_neg;
    logic [PW-1:0]        r_prod, n_prod;
    logic [MW-1:0]        r_rem, n_rem;
    logic [QW-1:0]        r_quo, n_quo;
    logic signed [BW-1:0] r_base, n_base;
    logic signed [DW-1:0] r_y, n_y;
    logic [2:0]           r_st, n_st;

    // RAM port signals.
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [2*DW-1:0]      w_wdata;
    logic [AW-1:0]        w_raddr;
    logic [2*DW-1:0]      w_rdata;
    logic signed [DW-1:0] w_rd_x;
    logic signed [DW-1:0] w_rd_y;

    // Datapath intermediates.
    logic                 w_accept;
    logic [CW-1:0]        w_cnt_m1;
    logic [CW-1:0]        w_cnt_m2;
    logic [AW-1:0]        w_sp0;
    logic signed [MW-1:0] w_seg_a;
    logic signed [MW-1:0] w_seg_b;
    logic                 w_off;
    logic signed [MW-1:0] w_dy;
    logic signed [MW-1:0] w_dx;
    logic signed [MW-1:0] w_d;
    logic [2*MW-1:0]      w_prod;
    logic [MW:0]          w_trial;
    logic [MW:0]          w_trial_sub;
    logic                 w_ge;
    logic signed [BW-1:0] w_qext;
    logic signed [BW-1:0] w_adj;

    assign w_accept = start && !busy;
    assign w_cnt_m1 = r_count - CW'(1);
    assign w_cnt_m2 = r_count - CW'(2);
    assign w_sp0    = i_first_query ? '0 : r_sp;
    assign w_rd_x   = w_rdata[2*DW-1:DW];
    assign w_rd_y   = w_rdata[DW-1:0];

    // Append port of the breakpoint table.
    assign w_we    = w_accept && (i_opcode == pic_pkg::OP_APPEND) &&
                     (r_count < CW'(MAX_POINTS));
    assign w_waddr = r_count[AW-1:0];
    assign w_wdata = {i_x_value, i_y_value};

    pic_ram #(
        .WIDTH (2 * pic_pkg::DW),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Segment test: the target lies strictly outside [a.x, b.x] by the product sign rule.
    assign w_seg_a = {r_x[DW-1], r_x} - {r_ax[DW-1], r_ax};
    assign w_seg_b = {w_rd_x[DW-1], w_rd_x} - {r_x[DW-1], r_x};
    assign w_off   = (!w_seg_a[MW-1] && (w_seg_a != '0) && w_seg_b[MW-1]) ||
                     (w_seg_a[MW-1] && !w_seg_b[MW-1] && (w_seg_b != '0));

    // Differences of the chosen segment.
    assign w_dy = {r_ay[DW-1], r_ay} - {r_by[DW-1], r_by};
    assign w_dx = {r_x[DW-1], r_x} - {r_bx[DW-1], r_bx};
    assign w_d  = {r_ax[DW-1], r_ax} - {r_bx[DW-1], r_bx};

    // Magnitude product and one restoring divide step.
    assign w_prod      = r_ma * r_mb;
    assign w_trial     = {r_rem, r_prod[QW-1]};
    assign w_trial_sub = w_trial - {1'b0, r_dm};
    assign w_ge        = (w_trial >= {1'b0, r_dm});

    // Signed quotient and truncation toward zero.
    assign w_qext = r_neg ? -$signed({{(BW-QW){1'b0}}, r_quo})
                          :  $signed({{(BW-QW){1'b0}}, r_quo});
    assign w_adj  = (r_rem != '0 && r_neg && r_base > 0)   ? r_base - BW'(1) :
                    (r_rem != '0 && !r_neg && r_base < 0)  ? r_base + BW'(1) :
                    r_base;

    // Read address follows the sequencer state.
    always_comb begin
        unique case (r_state)
            pic_pkg::S_A0:   w_raddr = '0;
            pic_pkg::S_AL:   w_raddr = r_last;
            pic_pkg::S_CMP: begin
                if (r_x < r_ax) begin
                    w_raddr = AW'(1);
                end else if (r_x > w_rd_x) begin
                    w_raddr = r_last_seg;
                end else begin
                    w_raddr = r_sp;
                end
            end
            pic_pkg::S_SEGA: w_raddr = r_sp + AW'(1);
            pic_pkg::S_SEGB: w_raddr = r_sp + AW'(2);
            default:         w_raddr = '0;
        endcase
    end

    // Sequencer next state and datapath updates.
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_sp       = r_sp;
        n_last     = r_last;
        n_last_seg = r_last_seg;
        n_cnt      = r_cnt;
        n_valid    = 1'b0;
        n_x        = r_x;
        n_ax       = r_ax;
        n_ay       = r_ay;
        n_bx       = r_bx;
        n_by       = r_by;
        n_ma       = r_ma;
        n_mb       = r_mb;
        n_dm       = r_dm;
        n_neg      = r_neg;
        n_prod     = r_prod;
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_base     = r_base;
        n_y        = r_y;
        n_st       = r_st;

        unique case (r_state)
            pic_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_y  = '0;
                    n_st = pic_pkg::ST_OK;
                    unique case (i_opcode)
                        pic_pkg::OP_CLEAR: begin
                            n_count = '0;
                            n_sp    = '0;
                            n_valid = 1'b1;
                        end
                        pic_pkg::OP_APPEND: begin
                            if (r_count < CW'(MAX_POINTS)) begin
                                n_count = r_count + CW'(1);
                            end else begin
                                n_st = pic_pkg::ST_FULL;
                            end
                            n_valid = 1'b1;
                        end
                        pic_pkg::OP_QUERY: begin
                            n_x = i_x_value;
                            if (r_count < CW'(2)) begin
                                n_sp    = w_sp0;
                                n_st    = pic_pkg::ST_FEW;
                                n_valid = 1'b1;
                            end else begin
                                // Clamp a stale pointer to the last segment.
                                n_sp       = (w_sp0 > w_cnt_m2[AW-1:0]) ? w_cnt_m2[AW-1:0]
                                                                        : w_sp0;
                                n_last     = w_cnt_m1[AW-1:0];
                                n_last_seg = w_cnt_m2[AW-1:0];
                                n_state    = pic_pkg::S_A0;
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            pic_pkg::S_A0: begin
                n_state = pic_pkg::S_AL;
            end
            pic_pkg::S_AL: begin
                // First breakpoint arrives.
                n_ax    = w_rd_x;
                n_ay    = w_rd_y;
                n_state = pic_pkg::S_CMP;
            end
            pic_pkg::S_CMP: begin
                // Last breakpoint arrives; choose extrapolation or search.
                if (r_x < r_ax) begin
                    n_state = pic_pkg::S_GETB;
                end else if (r_x > w_rd_x) begin
                    n_ax    = w_rd_x;
                    n_ay    = w_rd_y;
                    n_state = pic_pkg::S_GETB;
                end else begin
                    n_state = pic_pkg::S_SEGA;
                end
            end
            pic_pkg::S_SEGA: begin
                n_ax    = w_rd_x;
                n_ay    = w_rd_y;
                n_state = pic_pkg::S_SEGB;
            end
            pic_pkg::S_SEGB: begin
                // Step forward while the target lies off the current segment.
                if (r_sp < r_last_seg && w_off) begin
                    n_sp = r_sp + AW'(1);
                    n_ax = w_rd_x;
                    n_ay = w_rd_y;
                end else begin
                    n_bx    = w_rd_x;
                    n_by    = w_rd_y;
                    n_state = pic_pkg::S_DIFF;
                end
            end
            pic_pkg::S_GETB: begin
                n_bx    = w_rd_x;
                n_by    = w_rd_y;
                n_state = pic_pkg::S_DIFF;
            end
            pic_pkg::S_DIFF: begin
                if (w_d == '0) begin
                    n_y     = r_ay;
                    n_st    = pic_pkg::ST_ZERO;
                    n_valid = 1'b1;
                    n_state = pic_pkg::S_IDLE;
                end else begin
                    n_ma    = w_dy[MW-1] ? MW'(-w_dy) : MW'(w_dy);
                    n_mb    = w_dx[MW-1] ? MW'(-w_dx) : MW'(w_dx);
                    n_dm    = w_d[MW-1]  ? MW'(-w_d)  : MW'(w_d);
                    n_neg   = (w_dy[MW-1] ^ w_dx[MW-1] ^ w_d[MW-1]) &&
                              (w_dy != '0) && (w_dx != '0);
                    n_state = pic_pkg::S_MUL;
                end
            end
            pic_pkg::S_MUL: begin
                n_prod  = w_prod[PW-1:0];
                n_state = pic_pkg::S_OVF;
            end
            pic_pkg::S_OVF: begin
                // The quotient overflows when the top product bits reach the divisor.
                if ({{(MW-HW){1'b0}}, r_prod[PW-1:QW]} >= r_dm) begin
                    n_y     = r_neg ? pic_pkg::Y_MIN : pic_pkg::Y_MAX;
                    n_st    = pic_pkg::ST_SAT;
                    n_valid = 1'b1;
                    n_state = pic_pkg::S_IDLE;
                end else begin
                    n_rem   = {{(MW-HW){1'b0}}, r_prod[PW-1:QW]};
                    n_cnt   = CNTW'(QW - 1);
                    n_state = pic_pkg::S_DIV;
                end
            end
            pic_pkg::S_DIV: begin
                // One quotient bit per cycle, most significant first.
                n_rem  = w_ge ? w_trial_sub[MW-1:0] : w_trial[MW-1:0];
                n_quo  = {r_quo[QW-2:0], w_ge};
                n_prod = r_prod << 1;
                n_cnt  = r_cnt - CNTW'(1);
                if (r_cnt == '0) begin
                    n_state = pic_pkg::S_BASE;
                end
            end
            pic_pkg::S_BASE: begin
                n_base  = $signed({{(BW-DW){r_by[DW-1]}}, r_by}) + w_qext;
                n_state = pic_pkg::S_DONE;
            end
            pic_pkg::S_DONE: begin
                // Saturate to the 32-bit range.
                if (w_adj > $signed({{(BW-DW){1'b0}}, pic_pkg::Y_MAX})) begin
                    n_y  = pic_pkg::Y_MAX;
                    n_st = pic_pkg::ST_SAT;
                end else if (w_adj < $signed({{(BW-DW){1'b1}}, pic_pkg::Y_MIN})) begin
                    n_y  = pic_pkg::Y_MIN;
                    n_st = pic_pkg::ST_SAT;
                end else begin
                    n_y  = w_adj[DW-1:0];
                    n_st = pic_pkg::ST_OK;
                end
                n_valid = 1'b1;
                n_state = pic_pkg::S_IDLE;
            end
            default: begin
                n_state = pic_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= pic_pkg::S_IDLE;
            r_count    <= '0;
            r_sp       <= '0;
            r_last     <= '0;
            r_last_seg <= '0;
            r_cnt      <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_sp       <= n_sp;
            r_last     <= n_last;
            r_last_seg <= n_last_seg;
            r_cnt      <= n_cnt;
            r_valid    <= n_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_ax   <= n_ax;
        r_ay   <= n_ay;
        r_bx   <= n_bx;
        r_by   <= n_by;
        r_ma   <= n_ma;
        r_mb   <= n_mb;
        r_dm   <= n_dm;
        r_neg  <= n_neg;
        r_prod <= n_prod;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_base <= n_base;
        r_y    <= n_y;
        r_st   <= n_st;
    end

    assign busy       = (r_state != pic_pkg::S_IDLE);
    assign o_valid    = r_valid;
    assign o_y_result = r_y;
    assign o_status   = r_st;

    // A result beat is only ever shown while the sequencer rests.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == pic_pkg::S_IDLE))
        else $error("result beat while sequencer busy");

    // A clear beat empties the table and answers at once.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_opcode == pic_pkg::OP_CLEAR) |=>
        (r_valid && r_count == '0 && r_sp == '0 && r_st == pic_pkg::ST_OK))
        else $error("clear did not empty the table");

    // The fill count never passes the table depth.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_POINTS))
        else $error("breakpoint count beyond table depth");

    // The forward search never passes the last segment.
    a_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pic_pkg::S_SEGB) |-> (r_sp <= r_last_seg))
        else $error("search pointer past last segment");

    // A saturated result sits on one of the two limits.
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_st == pic_pkg::ST_SAT) |->
        (r_y == pic_pkg::Y_MAX || r_y == pic_pkg::Y_MIN))
        else $error("saturated result off the limits");

endmodule

// ===== tb/tb_piecewise_linear_interpolator_core.sv =====
// Self-checking testbench for the piecewise linear interpolator core.
// Needs pic_pkg and piecewise_linear_interpolator_core; a built-in table predictor
// computes the expected result of every beat that carries no typed-in expectation.
module tb_piecewise_linear_interpolator_core;

    localparam int                  NPTS     = 64;
    localparam logic [1:0]          OP_SPARE = 2'd3;
    localparam logic signed [31:0]  Q_ONE    = 32'sh0001_0000;
    localparam logic signed [31:0]  W_MIN    = 32'sh8000_0000;
    localparam logic signed [31:0]  W_MAX    = 32'sh7fff_ffff;
    localparam int                  N_DIRECT = 27;
    localparam int                  N_RANDOM = 1400;

    typedef struct packed {
        logic signed [31:0] y;
        logic [2:0]         st;
    } t_interp_out;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               fq;
        logic               fixed;
        logic signed [31:0] ey;
        logic [2:0]         es;
    } t_plan_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_opcode = pic_pkg::OP_CLEAR;
    logic signed [31:0] i_x_value = '0;
    logic signed [31:0] i_y_value = '0;
    logic               i_first_query = 1'b0;
    logic               o_valid;
    logic signed [31:0] o_y_result;
    logic [2:0]         o_status;

    // Typed-in expectation that travels with a directed beat.
    logic               row_fixed = 1'b0;
    logic signed [31:0] row_y = '0;
    logic [2:0]         row_st = pic_pkg::ST_OK;

    // Predictor copy of the breakpoint table and search pointer.
    logic signed [31:0] tbl_x [NPTS];
    logic signed [31:0] tbl_y [NPTS];
    int                 tbl_count = 0;
    int                 seg_ptr = 0;

    t_interp_out        pending_results [$];
    t_interp_out        head;
    t_interp_out        calc;
    int                 errors = 0;
    int                 beats_sent = 0;
    longint             tab_lo = 0;
    longint             tab_hi = 0;
    t_plan_row          plan [N_DIRECT];

    piecewise_linear_interpolator_core #(
        .MAX_POINTS(NPTS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_opcode      (i_opcode),
        .i_x_value     (i_x_value),
        .i_y_value     (i_y_value),
        .i_first_query (i_first_query),
        .o_valid       (o_valid),
        .o_y_result    (o_y_result),
        .o_status      (o_status)
    );

    // Clock with a 10 unit period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // True when x lies strictly outside segment p, judged by the signs of both ends.
    function automatic bit off_segment(input longint xq, input int p);
        longint a;
        longint b;
        a = xq - longint'(tbl_x[p]);
        b = longint'(tbl_x[p + 1]) - xq;
        return (a > 0 && b < 0) || (a < 0 && b > 0);
    endfunction

    // Value on the line through points i1 and i2, truncated toward zero and saturated.
    function automatic t_interp_out line_value(input longint xq, input int i1, input int i2);
        t_interp_out  r;
        longint       x1, x2, y1, y2, dy, dx, d, qv, base, yv;
        logic [127:0] am, bm, dm, prod, quo, rem;
        bit           neg;
        x1 = longint'(tbl_x[i1]);
        x2 = longint'(tbl_x[i2]);
        y1 = longint'(tbl_y[i1]);
        y2 = longint'(tbl_y[i2]);
        dy = y1 - y2;
        dx = xq - x2;
        d  = x1 - x2;
        r.st = pic_pkg::ST_OK;
        if (d == 0) begin
            r.y  = y1[31:0];
            r.st = pic_pkg::ST_ZERO;
            return r;
        end
        neg  = ((dy < 0) != (dx < 0)) != (d < 0);
        am   = 128'((dy < 0) ? -dy : dy);
        bm   = 128'((dx < 0) ? -dx : dx);
        dm   = 128'((d < 0) ? -d : d);
        prod = am * bm;
        quo  = prod / dm;
        rem  = prod % dm;
        // A quotient that needs more than 34 bits saturates with the raw sign.
        if (quo >= (128'd1 << 34)) begin
            r.y  = neg ? W_MIN : W_MAX;
            r.st = pic_pkg::ST_SAT;
            return r;
        end
        if (dy == 0 || dx == 0) begin
            neg = 1'b0;
        end
        qv   = longint'(quo[33:0]);
        base = y2 + (neg ? -qv : qv);
        yv   = base;
        if (rem != 0) begin
            if (neg && base > 0) begin
                yv = base - 1;
            end else if (!neg && base < 0) begin
                yv = base + 1;
            end
        end
        if (yv > 64'sd2147483647) begin
            r.y  = W_MAX;
            r.st = pic_pkg::ST_SAT;
        end else if (yv < -64'sd2147483648) begin
            r.y  = W_MIN;
            r.st = pic_pkg::ST_SAT;
        end else begin
            r.y = yv[31:0];
        end
        return r;
    endfunction

    // Expected result of one accepted beat; updates the predictor's table state.
    function automatic t_interp_out compute_interp_result(input logic [1:0] op,
                                                          input logic signed [31:0] xv,
                                                          input logic signed [31:0] yv,
                                                          input logic fq);
        t_interp_out r;
        longint      xq;
        int          n;
        r.y  = '0;
        r.st = pic_pkg::ST_OK;
        xq   = longint'(xv);
        n    = tbl_count;
        case (op)
            pic_pkg::OP_CLEAR: begin
                tbl_count = 0;
                seg_ptr   = 0;
            end
            pic_pkg::OP_APPEND: begin
                if (tbl_count < NPTS) begin
                    tbl_x[tbl_count] = xv;
                    tbl_y[tbl_count] = yv;
                    tbl_count++;
                end else begin
                    r.st = pic_pkg::ST_FULL;
                end
            end
            pic_pkg::OP_QUERY: begin
                if (fq) begin
                    seg_ptr = 0;
                end
                if (n < 2) begin
                    r.st = pic_pkg::ST_FEW;
                end else begin
                    if (seg_ptr > n - 2) begin
                        seg_ptr = n - 2;
                    end
                    if (xq < tbl_x[0]) begin
                        r = line_value(xq, 0, 1);
                    end else if (xq > tbl_x[n - 1]) begin
                        r = line_value(xq, n - 1, n - 2);
                    end else begin
                        while (seg_ptr < n - 2 && off_segment(xq, seg_ptr)) begin
                            seg_ptr++;
                        end
                        r = line_value(xq, seg_ptr, seg_ptr + 1);
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Scoreboard: check result beats in order, queue a prediction per accepted beat.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result beat, y_result %0d status %0d",
                             $time, o_y_result, o_status);
                    errors = errors + 1;
                end else begin
                    head = pending_results.pop_front();
                    if (o_y_result !== head.y) begin
                        $display("%0t: y_result expected %0d actual %0d",
                                 $time, head.y, o_y_result);
                        errors = errors + 1;
                    end
                    if (o_status !== head.st) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, head.st, o_status);
                        errors = errors + 1;
                    end
                end
            end
            if (start && !busy) begin
                calc = compute_interp_result(i_opcode, i_x_value, i_y_value, i_first_query);
                if (row_fixed) begin
                    calc.y  = row_y;
                    calc.st = row_st;
                end
                pending_results.push_back(calc);
            end
        end
    end

    // Present one beat and return at the edge that accepts it.
    task automatic send_beat(input logic [1:0] op, input logic signed [31:0] xv,
                             input logic signed [31:0] yv, input logic fq,
                             input logic fixed, input logic signed [31:0] ey,
                             input logic [2:0] es);
        bit steady;
        steady = beats_sent >= 500 && beats_sent < 800;
        if (!steady && $urandom_range(0, 99) < 29) begin
            start <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 40 : 6)) begin
                @(posedge i_clk);
            end
        end
        start         <= 1'b1;
        i_opcode      <= op;
        i_x_value     <= xv;
        i_y_value     <= yv;
        i_first_query <= fq;
        row_fixed     <= fixed;
        row_y         <= ey;
        row_st        <= es;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        beats_sent++;
    endtask

    // Random word, scaled down by an arithmetic shift to reach small magnitudes too.
    function automatic logic signed [31:0] rand_word(input int sh);
        logic signed [31:0] v;
        v = $urandom;
        return v >>> sh;
    endfunction

    // Target x: mostly inside the loaded span, sometimes just outside or anywhere.
    function automatic logic signed [31:0] pick_target();
        longint     v;
        bit [63:0]  r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       v = longint'(rand_word($urandom_range(0, 31)));
            1:       v = tab_lo - longint'(r[19:0]) - 1;
            2:       v = tab_hi + longint'(r[19:0]) + 1;
            default: v = (tab_hi > tab_lo) ? tab_lo + longint'(r % (tab_hi - tab_lo + 1))
                                           : tab_lo;
        endcase
        if (v > 64'sd2147483647) begin
            v = 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            v = -64'sd2147483648;
        end
        return v[31:0];
    endfunction

    // Append k breakpoints, mostly in ascending x with the odd repeated x.
    task automatic load_points(input int k);
        longint xs [$];
        longint ext [$];
        int     sx;
        int     sy;
        sx = $urandom_range(0, 20);
        sy = $urandom_range(0, 31);
        for (int i = 0; i < k; i++) begin
            xs.push_back(longint'(rand_word(sx)));
        end
        if ($urandom_range(0, 99) < 92) begin
            xs.sort();
            for (int i = 1; i < k; i++) begin
                if ($urandom_range(0, 19) == 0) begin
                    xs[i] = xs[i - 1];
                end
            end
        end
        if (k > 0) begin
            ext    = xs.min();
            tab_lo = ext[0];
            ext    = xs.max();
            tab_hi = ext[0];
        end
        for (int i = 0; i < k; i++) begin
            send_beat(pic_pkg::OP_APPEND, xs[i][31:0], rand_word(sy),
                      1'($urandom_range(0, 1)), 1'b0, '0, pic_pkg::ST_OK);
        end
    endtask

    // A run of queries, usually in ascending x so the forward search is exercised.
    task automatic run_queries(input int nq);
        longint qs [$];
        for (int i = 0; i < nq; i++) begin
            qs.push_back(longint'(pick_target()));
        end
        if ($urandom_range(0, 99) < 75) begin
            qs.sort();
        end
        for (int i = 0; i < nq; i++) begin
            send_beat(pic_pkg::OP_QUERY, qs[i][31:0], $urandom,
                      (i == 0) ? ($urandom_range(0, 99) < 80) : ($urandom_range(0, 9) == 0),
                      1'b0, '0, pic_pkg::ST_OK);
        end
    endtask

    // Stimulus: reset, directed table, then random load and query sequences.
    initial begin
        int k;
        int pick;
        plan = '{
            '{pic_pkg::OP_QUERY,  Q_ONE,   '0,       1'b1, 1'b1, '0, pic_pkg::ST_FEW},
            '{OP_SPARE,           -32'sd1, -32'sd1,  1'b1, 1'b1, '0, pic_pkg::ST_OK},
            '{pic_pkg::OP_APPEND, '0,      '0,       1'b0, 1'b1, '0, pic_pkg::ST_OK},
            '{pic_pkg::OP_QUERY,  Q_ONE,   '0,       1'b0, 1'b1, '0, pic_pkg::ST_FEW},
            '{pic_pkg::OP_APPEND, Q_ONE,   3*Q_ONE,  1'b0, 1'b1, '0, pic_pkg::ST_OK},
            '{pic_pkg::OP_QUERY,  Q_ONE/2, '0,       1'b1, 1'b0, '0, pic_pkg::ST_OK},
            '{pic_pkg::OP_APPEND, 4*Q_ONE, -2*Q_ONE, 1'b0, 1'b1, '0, pic_pkg::ST_OK},
            '{pic_pkg::OP_APPEND, 6*Q_ONE, 5*Q_ONE,  1'b1, 1'b1, '0, pic_pkg::ST_OK},
            '{pic_pkg::OP_QUERY,  5*Q_ONE, '0,       1'b1, 1'b0, '0, pic_pkg::ST_OK},
            // Pointer stays on the last segment without the first-query flag.
            '{pic_pkg::OP_QUERY,  Q_ONE/4, '0,       1'b0, 1'b0, '0, pic_pkg::ST_OK},
            '{pic_pkg::OP_QUERY,  Q_ONE/4, '0,       1'b1, 1'b0, '0, pic_pkg::ST_OK},
            '{pic_pkg::OP_QUERY,  W_MIN,   '0,       1'b0, 1'b0, '0, pic_pkg::ST_OK},
            '{pic_pkg::OP_QUERY,  W_MAX,   '0,       1'b0, 1'b0, '0, pic_pkg::ST_OK},
            '{pic_pkg::OP_CLEAR,  -32'sd1, -32'sd1,  1'b1, 1'b1, '0, pic_pkg::ST_OK},
            '{pic_pkg::OP_APPEND, W_MIN,   W_MIN,    1'b0, 1'b1, '0, pic_pkg::ST_OK},
            '{pic_pkg::OP_APPEND, W_MAX,   W_MAX,    1'b0, 1'b1, '0, pic_pkg::ST_OK},
            '{pic_pkg::OP_QUERY,  '0,      '0,       1'b1, 1'b0, '0, pic_pkg::ST_OK},
            '{pic_pkg::OP_QUERY,  -32'sd1, '0,       1'b0, 1'b0, '0, pic_pkg::ST_OK},
            // Two points with the same x form a zero-width segment.
            '{pic_pkg::OP_CLEAR,  '0,      '0,       1'b0, 1'b1, '0, pic_pkg::ST_OK},
            '{pic_pkg::OP_APPEND, Q_ONE,   32'sd7,   1'b0, 1'b1, '0, pic_pkg::ST_OK},
            '{pic_pkg::OP_APPEND, Q_ONE,   32'sd9,   1'b0, 1'b1, '0, pic_pkg::ST_OK},
            '{pic_pkg::OP_QUERY,  Q_ONE,   '0,       1'b1, 1'b1, 32'sd7, pic_pkg::ST_ZERO},
            // Steep segment: extrapolation at both extremes saturates.
            '{pic_pkg::OP_CLEAR,  '0,      '0,       1'b0, 1'b1, '0, pic_pkg::ST_OK},
            '{pic_pkg::OP_APPEND, '0,      '0,       1'b0, 1'b1, '0, pic_pkg::ST_OK},
            '{pic_pkg::OP_APPEND, 32'sd1,  W_MAX,    1'b0, 1'b1, '0, pic_pkg::ST_OK},
            '{pic_pkg::OP_QUERY,  W_MAX,   '0,       1'b0, 1'b1, pic_pkg::Y_MAX,
              pic_pkg::ST_SAT},
            '{pic_pkg::OP_QUERY,  W_MIN,   '0,       1'b1, 1'b1, pic_pkg::Y_MIN,
              pic_pkg::ST_SAT}
        };
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECT; i++) begin
            send_beat(plan[i].op, plan[i].x, plan[i].y, plan[i].fq,
                      plan[i].fixed, plan[i].ey, plan[i].es);
        end

        // Fill past capacity once so the full-table drop is seen early.
        send_beat(pic_pkg::OP_CLEAR, $urandom, $urandom, 1'b0, 1'b0, '0, pic_pkg::ST_OK);
        load_points(NPTS + 3);
        run_queries(8);

        while (beats_sent < N_RANDOM) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                if ($urandom_range(0, 99) < 80) begin
                    send_beat(pic_pkg::OP_CLEAR, $urandom, $urandom,
                              1'($urandom_range(0, 1)), 1'b0, '0, pic_pkg::ST_OK);
                end
                k = $urandom_range(0, 99);
                if (k < 5) begin
                    k = $urandom_range(0, 1);
                end else if (k < 92) begin
                    k = $urandom_range(2, 10);
                end else if (k < 97) begin
                    k = $urandom_range(11, 40);
                end else begin
                    k = $urandom_range(60, NPTS + 4);
                end
                load_points(k);
                run_queries($urandom_range(1, 12));
            end else begin
                // Noise: any opcode with unrestricted fields.
                repeat ($urandom_range(1, 4)) begin
                    send_beat(2'($urandom_range(0, 3)), $urandom, $urandom,
                              1'($urandom_range(0, 1)), 1'b0, '0, pic_pkg::ST_OK);
                end
            end
        end
        start <= 1'b0;

        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (150) @(posedge i_clk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
